@@ sv/rpm_pkg.sv @@
// Shared types and constants of the block RMS and peak level meter.
`timescale 1ns / 1ps
`default_nettype none

package rpm_pkg;

    // Sample and level widths fixed by the interface
    localparam int SAMPLE_BITS = 24;
    localparam int MAG_W       = SAMPLE_BITS;
    localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
    localparam int MEAN_W      = 2 * SAMPLE_BITS - 1;
    localparam int RAD_W       = 2 * SAMPLE_BITS;
    localparam int ROOT_W      = SAMPLE_BITS;
    localparam int SREM_W      = ROOT_W + 3;

    // Epsilon 1e-10 scaled by 2^46, rounded
    localparam logic [RAD_W-1:0] RMS_EPSILON = RAD_W'(7037);

    // Block record queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_queue_stat;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_DONE = 4'b1000
    } t_back_state;

endpackage

`default_nettype wire

@@ sv/rpm_queue.sv @@
// Short FIFO of finished block records between the front and back sections.
`timescale 1ns / 1ps
`default_nettype none

module rpm_queue #(
    parameter int WIDTH = 97
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic [WIDTH-1:0]    i_data,
    input  wire logic                i_pop,
    output logic [WIDTH-1:0]         o_data,
    output rpm_pkg::t_queue_stat     o_stat
);

    logic [WIDTH-1:0]          r_mem [rpm_pkg::QUEUE_DEPTH];
    logic [rpm_pkg::QIDX_W-1:0] r_wr_ptr;
    logic [rpm_pkg::QIDX_W-1:0] r_rd_ptr;
    logic [rpm_pkg::QCNT_W-1:0] r_count;
    logic                       w_do_push;
    logic                       w_do_pop;

    assign w_do_push = i_push && (r_count != rpm_pkg::QCNT_W'(rpm_pkg::QUEUE_DEPTH));
    assign w_do_pop  = i_pop && (r_count != '0);

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == rpm_pkg::QCNT_W'(rpm_pkg::QUEUE_DEPTH));
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

@@ sv/rpm_front.sv @@
// Front section: sample magnitude, squaring and per-block accumulation.
`timescale 1ns / 1ps
`default_nettype none

module rpm_front #(
    parameter int MAX_BLOCK_SAMPLES = 4096,
    parameter int CNT_W             = $clog2(MAX_BLOCK_SAMPLES + 1),
    parameter int SUM_W             = rpm_pkg::SQ_W - 1 + CNT_W,
    parameter int REC_W             = SUM_W + CNT_W + rpm_pkg::MAG_W + 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [rpm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                              i_last_of_block,
    output logic                                   o_push,
    output logic [REC_W-1:0]                       o_rec,
    input  rpm_pkg::t_queue_stat                   i_qstat
);

    localparam int MAG_W  = rpm_pkg::MAG_W;
    localparam int SQ_W   = rpm_pkg::SQ_W;
    localparam int HOLD_W = rpm_pkg::QCNT_W + 1;

    // Stage A: magnitude
    logic             r_a_vld;
    logic             r_a_last;
    logic [MAG_W-1:0] r_a_mag;
    // Stage B: square
    logic             r_b_vld;
    logic             r_b_last;
    logic [MAG_W-1:0] r_b_mag;
    logic [SQ_W-1:0]  r_b_sq;
    // Block accumulators
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic [MAG_W-1:0] r_peak;
    logic             r_ovf;

    logic               w_accept;
    logic [MAG_W-1:0]   n_a_mag;
    logic [2*MAG_W-1:0] w_sq_full;
    logic               w_at_max;
    logic [SUM_W-1:0]   n_sum;
    logic [CNT_W-1:0]   n_count;
    logic [MAG_W-1:0]   n_peak;
    logic               n_ovf;
    logic [HOLD_W-1:0]  w_held;

    // Hold off input while the queue could not take every block end in flight
    assign w_held = HOLD_W'(i_qstat.count)
                  + HOLD_W'(r_a_vld & r_a_last)
                  + HOLD_W'(r_b_vld & r_b_last);
    assign o_ready  = (w_held < HOLD_W'(rpm_pkg::QUEUE_DEPTH));
    assign w_accept = i_valid && o_ready;

    // Two's complement magnitude; the most negative sample maps to 2^23
    assign n_a_mag = i_sample[rpm_pkg::SAMPLE_BITS-1]
                   ? (~$unsigned(i_sample) + MAG_W'(1))
                   : $unsigned(i_sample);

    assign w_sq_full = {{MAG_W{1'b0}}, r_a_mag} * {{MAG_W{1'b0}}, r_a_mag};

    // Advance the magnitude and square stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= w_accept;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mag  <= n_a_mag;
        r_a_last <= i_last_of_block;
        r_b_mag  <= r_a_mag;
        r_b_last <= r_a_last;
        r_b_sq   <= w_sq_full[SQ_W-1:0];
    end

    // Fold the squared sample into the block totals; saturate past the limit
    always_comb begin
        w_at_max = (r_count >= CNT_W'(MAX_BLOCK_SAMPLES));
        n_sum    = w_at_max ? r_sum : (r_sum + SUM_W'(r_b_sq));
        n_count  = w_at_max ? r_count : (r_count + CNT_W'(1));
        n_ovf    = r_ovf | w_at_max;
        n_peak   = (r_b_mag > r_peak) ? r_b_mag : r_peak;
    end

    // Update totals, clear them at block end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_peak  <= '0;
            r_ovf   <= 1'b0;
        end else if (r_b_vld) begin
            if (r_b_last) begin
                r_sum   <= '0;
                r_count <= '0;
                r_peak  <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
                r_peak  <= n_peak;
                r_ovf   <= n_ovf;
            end
        end
    end

    // Hand the closed block to the queue
    assign o_push = r_b_vld && r_b_last;
    assign o_rec  = {n_sum, n_count, n_peak, n_ovf};

`ifndef ASSERT_OFF
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCK_SAMPLES))
        else $error("sample count exceeds block limit");

    a_ovf_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_W'(MAX_BLOCK_SAMPLES)))
        else $error("overflow flag set below block limit");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_qstat.full)
        else $error("block record pushed into full queue");
`endif

endmodule

`default_nettype wire

@@ sv/rpm_back.sv @@
// Back section: iterative mean division, square root and result register.
`timescale 1ns / 1ps
`default_nettype none

module rpm_back #(
    parameter int MAX_BLOCK_SAMPLES = 4096,
    parameter int CNT_W             = $clog2(MAX_BLOCK_SAMPLES + 1),
    parameter int SUM_W             = rpm_pkg::SQ_W - 1 + CNT_W,
    parameter int REC_W             = SUM_W + CNT_W + rpm_pkg::MAG_W + 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [REC_W-1:0]           i_rec,
    input  rpm_pkg::t_queue_stat            i_qstat,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [rpm_pkg::ROOT_W-1:0]      o_rms_level,
    output logic [rpm_pkg::MAG_W-1:0]       o_peak_level,
    output logic                            o_too_long
);

    localparam int MAG_W  = rpm_pkg::MAG_W;
    localparam int ROOT_W = rpm_pkg::ROOT_W;
    localparam int RAD_W  = rpm_pkg::RAD_W;
    localparam int SREM_W = rpm_pkg::SREM_W;
    localparam int MEAN_W = rpm_pkg::MEAN_W;
    localparam int STEP_W = $clog2(SUM_W);

    rpm_pkg::t_back_state r_state;

    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;
    logic [RAD_W-1:0]  r_rad;
    logic [SREM_W-1:0] r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [MAG_W-1:0]  r_peak;
    logic              r_ovf;
    logic              r_out_vld;
    logic [ROOT_W-1:0] r_out_rms;
    logic [MAG_W-1:0]  r_out_peak;
    logic              r_out_ovf;

    logic [SUM_W-1:0]  w_rec_sum;
    logic [CNT_W-1:0]  w_rec_cnt;
    logic [MAG_W-1:0]  w_rec_peak;
    logic              w_rec_ovf;
    logic [CNT_W:0]    w_dtrial;
    logic              w_dge;
    logic [SUM_W-1:0]  n_quo;
    logic [CNT_W-1:0]  n_rem;
    logic [SREM_W-1:0] w_strial;
    logic [SREM_W-1:0] w_sshift;
    logic              w_sge;
    logic [SREM_W-1:0] n_srem;
    logic [ROOT_W-1:0] n_root;
    logic              w_out_free;

    assign {w_rec_sum, w_rec_cnt, w_rec_peak, w_rec_ovf} = i_rec;

    // One restoring division step: bring down a dividend bit, subtract if it fits
    always_comb begin
        w_dtrial = {r_rem, r_quo[SUM_W-1]};
        w_dge    = (w_dtrial >= {1'b0, r_div});
        n_rem    = w_dge ? CNT_W'(w_dtrial - {1'b0, r_div}) : w_dtrial[CNT_W-1:0];
        n_quo    = {r_quo[SUM_W-2:0], w_dge};
    end

    // One digit-by-digit square root step over two radicand bits
    always_comb begin
        w_sshift = {r_srem[SREM_W-3:0], r_rad[RAD_W-1 -: 2]};
        w_strial = SREM_W'({r_root, 2'b01});
        w_sge    = (w_sshift >= w_strial);
        n_srem   = w_sge ? (w_sshift - w_strial) : w_sshift;
        n_root   = {r_root[ROOT_W-2:0], w_sge};
    end

    assign w_out_free = !r_out_vld || i_ready;
    assign o_pop      = (r_state == rpm_pkg::ST_IDLE) && !i_qstat.empty;

    // Sequence: take record, divide, root, hand off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpm_pkg::ST_IDLE;
        end else begin
            case (r_state)
                rpm_pkg::ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= rpm_pkg::ST_DIV;
                    end
                end
                rpm_pkg::ST_DIV: begin
                    if (r_step == '0) begin
                        r_state <= rpm_pkg::ST_SQRT;
                    end
                end
                rpm_pkg::ST_SQRT: begin
                    if (r_step == '0) begin
                        r_state <= rpm_pkg::ST_DONE;
                    end
                end
                rpm_pkg::ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= rpm_pkg::ST_IDLE;
                    end
                end
                default: r_state <= rpm_pkg::ST_IDLE;
            endcase
        end
    end

    // Datapath registers of the divider and the root unit
    always_ff @(posedge i_clk) begin
        case (r_state)
            rpm_pkg::ST_IDLE: begin
                r_quo  <= w_rec_sum;
                r_div  <= w_rec_cnt;
                r_rem  <= '0;
                r_peak <= w_rec_peak;
                r_ovf  <= w_rec_ovf;
                r_step <= STEP_W'(SUM_W - 1);
            end
            rpm_pkg::ST_DIV: begin
                r_quo  <= n_quo;
                r_rem  <= n_rem;
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_rad  <= RAD_W'(n_quo[MEAN_W-1:0]) + rpm_pkg::RMS_EPSILON;
                    r_srem <= '0;
                    r_root <= '0;
                    r_step <= STEP_W'(ROOT_W - 1);
                end
            end
            rpm_pkg::ST_SQRT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_srem <= n_srem;
                r_root <= n_root;
                r_step <= r_step - 1'b1;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // Output register: load when the result is done and the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == rpm_pkg::ST_DONE) && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == rpm_pkg::ST_DONE) && w_out_free) begin
            r_out_rms  <= r_root;
            r_out_peak <= r_peak;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_rms_level  = r_out_rms;
    assign o_peak_level = r_out_peak;
    assign o_too_long   = r_out_ovf;

`ifndef ASSERT_OFF
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpm_pkg::ST_DIV) |-> (r_rem < r_div))
        else $error("division remainder not below divisor");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpm_pkg::ST_DIV) |-> (r_div != '0))
        else $error("block record with zero sample count");

    a_rms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpm_pkg::ST_DONE) |-> (r_root <= ROOT_W'(8388608)))
        else $error("root result out of range");
`endif

endmodule

`default_nettype wire

@@ sv/block_rms_peak_meter_core.sv @@
// Top level of the block RMS and peak level meter.
//
// Input channel: i_valid / o_ready carry one signed Q1.23 sample (i_sample) and a
// last-of-block mark (i_last_of_block); a transfer happens when both are high.
// Output channel: o_valid / i_ready carry one result per block: RMS level, peak
// level and the too-long flag.
// Samples are taken one per cycle while o_ready is high. Each sample passes a
// magnitude and a square stage, then joins the running block totals. At the
// last sample the totals go as one record into a four-entry queue and are
// cleared for the next block. The back section pops a record, divides the sum
// of squares by the count one quotient bit per cycle, then takes the square
// root two radicand bits per cycle. It pops the next record only after its
// result is loaded into the output register; when blocks arrive faster than
// that, the queue fills and o_ready drops. When the receiver stalls, the
// result waits in the output register, the back section holds its next
// finished result, and input is held off once the queue cannot take more
// block ends. Reset empties the pipeline, the queue and the output register
// and clears the block totals.
`timescale 1ns / 1ps
`default_nettype none

module block_rms_peak_meter_core #(
    parameter int MAX_BLOCK_SAMPLES = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [rpm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                              i_last_of_block,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [rpm_pkg::ROOT_W-1:0]             o_rms_level,
    output logic [rpm_pkg::MAG_W-1:0]              o_peak_level,
    output logic                                   o_too_long
);

    localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int SUM_W = rpm_pkg::SQ_W - 1 + CNT_W;
    localparam int REC_W = SUM_W + CNT_W + rpm_pkg::MAG_W + 1;

    logic                 w_push;
    logic                 w_pop;
    logic [REC_W-1:0]     w_push_rec;
    logic [REC_W-1:0]     w_pop_rec;
    rpm_pkg::t_queue_stat w_qstat;

    // Accumulate samples per block
    rpm_front #(
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
        .CNT_W             (CNT_W),
        .SUM_W             (SUM_W),
        .REC_W             (REC_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .i_last_of_block (i_last_of_block),
        .o_push          (w_push),
        .o_rec           (w_push_rec),
        .i_qstat         (w_qstat)
    );

    // Buffer closed blocks
    rpm_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_rec),
        .i_pop   (w_pop),
        .o_data  (w_pop_rec),
        .o_stat  (w_qstat)
    );

    // Reduce each block to its levels
    rpm_back #(
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
        .CNT_W             (CNT_W),
        .SUM_W             (SUM_W),
        .REC_W             (REC_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec        (w_pop_rec),
        .i_qstat      (w_qstat),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_rms_level  (o_rms_level),
        .o_peak_level (o_peak_level),
        .o_too_long   (o_too_long)
    );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the block RMS and peak level meter.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_BLOCK    = 4096;
    localparam int LEVEL_EPS    = 7037;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 1550;

    localparam logic signed [23:0] FULL_POS = 24'sh7FFFFF;
    localparam logic signed [23:0] FULL_NEG = 24'sh800000;

    typedef struct packed {
        logic [23:0] rms;
        logic [23:0] peak;
        logic        too_long;
    } t_level_result;

    // Running block totals and the results they predict
    class t_level_scoreboard;
        t_level_result     expected_q[$];
        longint unsigned   square_acc;
        int unsigned       sample_cnt;
        int unsigned       peak_mag;
        bit                overlong;
        int                n_samples;
        int                n_blocks;
        int                n_overlong;
        int                n_errors;

        function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int i = 31; i >= 0; i--) begin
                trial = root | (64'd1 << i);
                if (trial * trial <= x) root = trial;
            end
            return root;
        endfunction

        function void note_sample(logic signed [23:0] s, logic last);
            int              v;
            longint unsigned mag;
            longint unsigned mean;
            t_level_result   r;
            v = s;
            if (v < 0) mag = longint'(-v);
            else mag = longint'(v);
            n_samples++;
            // Saturate count and sum past the block limit, keep tracking the peak
            if (sample_cnt >= MAX_BLOCK) begin
                overlong = 1'b1;
            end else begin
                square_acc += mag * mag;
                sample_cnt++;
            end
            if (mag > peak_mag) peak_mag = 32'(mag);
            if (!last) return;
            mean       = square_acc / sample_cnt;
            r.rms      = 24'(floor_sqrt(mean + LEVEL_EPS));
            r.peak     = 24'(peak_mag);
            r.too_long = overlong;
            expected_q.push_back(r);
            if (overlong) n_overlong++;
            square_acc = 0;
            sample_cnt = 0;
            peak_mag   = 0;
            overlong   = 1'b0;
        endfunction

        function void check_result(logic [23:0] rms, logic [23:0] peak, logic too_long);
            t_level_result e;
            bit            bad;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no block pending: rms %0d peak %0d too_long %0d",
                         $time, rms, peak, too_long);
                n_errors++;
                return;
            end
            e   = expected_q.pop_front();
            bad = 1'b0;
            n_blocks++;
            if (rms !== e.rms) begin
                $display("%0t: rms_level mismatch: expected %0d, actual %0d",
                         $time, e.rms, rms);
                bad = 1'b1;
            end
            if (peak !== e.peak) begin
                $display("%0t: peak_level mismatch: expected %0d, actual %0d",
                         $time, e.peak, peak);
                bad = 1'b1;
            end
            if (too_long !== e.too_long) begin
                $display("%0t: too_long mismatch: expected %0d, actual %0d",
                         $time, e.too_long, too_long);
                bad = 1'b1;
            end
            if (bad) n_errors++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                                      i_clk;
    logic                                      i_rst_n;
    logic                                      i_valid;
    logic                                      o_ready;
    logic signed [rpm_pkg::SAMPLE_BITS-1:0]    i_sample;
    logic                                      i_last_of_block;
    logic                                      o_valid;
    logic                                      i_ready;
    logic [rpm_pkg::ROOT_W-1:0]                o_rms_level;
    logic [rpm_pkg::MAG_W-1:0]                 o_peak_level;
    logic                                      o_too_long;

    t_level_scoreboard sb;
    bit                src_gaps;
    bit                snk_gaps;
    bit                hold_request;
    int                items_sent;
    int                stall_cycles;

    block_rms_peak_meter_core #(
        .MAX_BLOCK_SAMPLES(MAX_BLOCK)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .i_last_of_block(i_last_of_block),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_rms_level    (o_rms_level),
        .o_peak_level   (o_peak_level),
        .o_too_long     (o_too_long)
    );

    // Free-running clock, 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Note input transfers and check output transfers at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_sample(i_sample, i_last_of_block);
            if (i_valid && !o_ready) stall_cycles++;
            if (o_valid && i_ready) sb.check_result(o_rms_level, o_peak_level, o_too_long);
        end
    end

    // Receiver: random ready bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (snk_gaps && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offer one sample and hold it until the transfer
    task automatic send_sample(input logic signed [23:0] s, input logic last);
        @(negedge i_clk);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sample        <= s;
        i_last_of_block <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Mostly full-range samples, weighted toward the extremes
    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 24'($urandom());
            5:             return $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
            6:             return $urandom_range(0, 1) ? 24'sd1 : -24'sd1;
            7:             return 24'($urandom_range(0, 511)) - 24'sd256;
            8:             return FULL_POS - 24'($urandom_range(0, 255));
            default:       return FULL_NEG + 24'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly short blocks, now and then a longer one
    task automatic send_random_block();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
    endtask

    // Stop a hung run
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sb              = new();
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_sample        = '0;
        i_last_of_block = 1'b0;
        i_ready         = 1'b0;
        src_gaps        = 1'b1;
        snk_gaps        = 1'b1;
        hold_request    = 1'b0;
        items_sent      = 0;
        stall_cycles    = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-sample blocks at the extremes, most negative sample among them
        send_sample(24'sd0, 1'b1);
        send_sample(FULL_POS, 1'b1);
        send_sample(FULL_NEG, 1'b1);
        send_sample(-24'sd1, 1'b1);
        send_sample(24'sd1, 1'b1);
        // Short blocks with mixed signs and alternating bit patterns
        send_sample(FULL_POS, 1'b0);
        send_sample(FULL_NEG, 1'b1);
        send_sample(24'sd0, 1'b0);
        send_sample(24'sd0, 1'b0);
        send_sample(24'sd0, 1'b1);
        send_sample(24'sd1, 1'b0);
        send_sample(-24'sd1, 1'b0);
        send_sample(24'sd100, 1'b0);
        send_sample(FULL_NEG, 1'b1);
        send_sample(24'sh555555, 1'b0);
        send_sample(24'shAAAAAA, 1'b0);
        send_sample(24'sh0F0F0F, 1'b0);
        send_sample(24'shF0F0F0, 1'b0);
        send_sample(24'sh3FFFFF, 1'b1);

        // Random blocks with idling on both sides
        while (items_sent < RANDOM_ITEMS / 3) send_random_block();

        // Steady stretch with no idling
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        while (items_sent < RANDOM_ITEMS / 2) send_random_block();

        // Hold off the receiver and keep offering block ends to fill the queue
        src_gaps     = 1'b1;
        snk_gaps     = 1'b1;
        hold_request = 1'b1;
        repeat (40) send_sample(pick_sample(), 1'b1);

        while (items_sent < (RANDOM_ITEMS * 9) / 10) send_random_block();

        // Last part without idling
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        while (items_sent < RANDOM_ITEMS) send_random_block();

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain outstanding results, then watch for stray ones
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples in %0d checked blocks, %0d of them over the limit.",
                 sb.n_samples, sb.n_blocks, sb.n_overlong);
        $display("Input was held off for %0d cycles by the block.", stall_cycles);
        if (sb.n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
